### rtl/swept_circle_static_circle_defines.svh
// Assertion macros shared by the swept circle collision block.
// No dependencies; the including module provides clk and rst_n.
`ifndef SWEPT_CIRCLE_STATIC_CIRCLE_DEFINES_SVH
`define SWEPT_CIRCLE_STATIC_CIRCLE_DEFINES_SVH

`define SCV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SCV_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

### rtl/scv_pkg.sv
// Types, widths and arithmetic helpers for the swept circle collision block.
// No dependencies; used by every module of the block.
package scv_pkg;

  localparam int COORD_W     = 32;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int RAD_W       = COORD_W - 1;
  localparam int TFB         = 16;
  localparam int T_W         = TFB + 1;
  localparam int SQ_W        = 2 * DIFF_W;
  localparam int SUM_W       = SQ_W + 2;
  localparam int HALF_W      = SQ_W / 2;
  localparam int DISC_W      = 2 * SQ_W;
  localparam int ROOT_W      = SQ_W;
  localparam int REM_W       = ROOT_W + 1;
  localparam int DIV_W       = SQ_W + 1;
  localparam int PROD_W      = DIFF_W + T_W + 1;
  localparam int SQRT_CELLS  = ROOT_W;
  localparam int DIV_CELLS   = T_W;
  localparam int IN_W        = 9 * COORD_W + RAD_W;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = 1 + T_W + 3 * COORD_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [T_W-1:0] T_ONE = {1'b1, {TFB{1'b0}}};

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;

  typedef struct packed {
    logic               ok;
    logic [SQ_W-1:0]    a;
    logic [SQ_W-1:0]    b;
    diff_t [2:0]        mv;
    coord_t [2:0]       st;
  } side_t;

  typedef struct packed {
    logic [DISC_W-1:0]  rad;
    logic [REM_W-1:0]   rem;
    logic [ROOT_W-1:0]  root;
  } sqrt_t;

  typedef struct packed {
    logic [DIV_W-1:0]   r;
    logic [T_W-1:0]     q;
  } div_t;

  function automatic diff_t sub_ext(input coord_t x, input coord_t y);
    diff_t xe, ye;
    xe = {x[COORD_W-1], x};
    ye = {y[COORD_W-1], y};
    return xe - ye;
  endfunction

  function automatic logic signed [SQ_W-1:0] mul_s(input diff_t x, input diff_t y);
    logic signed [SQ_W-1:0] p;
    p = x * y;
    return p;
  endfunction

  function automatic logic [2*HALF_W-1:0] umul_h(input logic [HALF_W-1:0] x,
                                                 input logic [HALF_W-1:0] y);
    logic [2*HALF_W-1:0] p;
    p = x * y;
    return p;
  endfunction

  function automatic logic signed [PROD_W-1:0] mul_t(input diff_t m, input logic [T_W-1:0] t);
    logic signed [T_W:0]     ts;
    logic signed [PROD_W-1:0] p;
    ts = {1'b0, t};
    p  = m * ts;
    return p;
  endfunction

endpackage

### rtl/swept_circle_static_circle.sv
// Swept point against fixed sphere: entry time and contact point.
// Accepts one word per cycle unless the pipeline holds for a stalled output.
// The square root chain (66 cells) and the division chain (17 cells) set the depth.
// The whole pipeline holds only while the last stage and the output register are full.
// Reset is synchronous, active low, and clears only the valid flags.
`include "swept_circle_static_circle_defines.svh"
module swept_circle_static_circle (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, centre_x, centre_y,
  // centre_z, combined_radius, zero pad
  input  logic [scv_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // hit, impact_time, contact_x, contact_y, contact_z, zero pad
  output logic [scv_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  logic                                en;
  logic                                f_valid;
  scv_pkg::side_t                      f_side;
  logic [scv_pkg::DISC_W-1:0]          f_disc;

  logic                                sq_v    [scv_pkg::SQRT_CELLS+1];
  scv_pkg::side_t                      sq_side [scv_pkg::SQRT_CELLS+1];
  scv_pkg::sqrt_t                      sq_st   [scv_pkg::SQRT_CELLS+1];
  logic                                dv_v    [scv_pkg::DIV_CELLS+1];
  scv_pkg::side_t                      dv_side [scv_pkg::DIV_CELLS+1];
  scv_pkg::div_t                       dv_st   [scv_pkg::DIV_CELLS+1];

  logic                                e_v_r;
  scv_pkg::side_t                      e_side_r;
  logic [scv_pkg::SQ_W-1:0]            e_num_r, e_num_nxt;
  logic [scv_pkg::ROOT_W:0]            root_c;

  logic                                p_v_r, p_ok_r;
  logic [scv_pkg::T_W-1:0]             p_t_r, t_nxt;
  logic [2:0][scv_pkg::PROD_W-1:0]     p_prod_r;
  scv_pkg::coord_t [2:0]               p_st_r;
  scv_pkg::coord_t [2:0]               contact;

  logic                                out_valid_r;
  logic [scv_pkg::OUT_TDATA_W-1:0]     out_data_r, out_nxt;

  assign en         = out_tready || !out_valid_r || !p_v_r;
  assign in_tready  = en;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  scv_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .i_valid (in_tvalid),
    .i_data  (in_tdata),
    .o_valid (f_valid),
    .o_side  (f_side),
    .o_disc  (f_disc)
  );

  always_comb begin
    sq_v[0]          = f_valid;
    sq_side[0]       = f_side;
    sq_st[0].rad     = f_disc;
    sq_st[0].rem     = '0;
    sq_st[0].root    = '0;
  end

  for (genvar g = 0; g < scv_pkg::SQRT_CELLS; g++) begin : g_sqrt
    scv_sqrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .i_valid (sq_v[g]),
      .i_side  (sq_side[g]),
      .i_sq    (sq_st[g]),
      .o_valid (sq_v[g+1]),
      .o_side  (sq_side[g+1]),
      .o_sq    (sq_st[g+1])
    );
  end

  // Rounding the root up keeps the reported time at or before the true entry.
  always_comb begin
    root_c = {1'b0, sq_st[scv_pkg::SQRT_CELLS].root}
           + (scv_pkg::ROOT_W + 1)'(sq_st[scv_pkg::SQRT_CELLS].rem != '0);
    if (root_c > {1'b0, sq_side[scv_pkg::SQRT_CELLS].b}) begin
      e_num_nxt = '0;
    end else begin
      e_num_nxt = sq_side[scv_pkg::SQRT_CELLS].b - root_c[scv_pkg::ROOT_W-1:0];
    end
  end

  always_comb begin
    dv_v[0]    = e_v_r;
    dv_side[0] = e_side_r;
    dv_st[0].r = {1'b0, e_num_r};
    dv_st[0].q = '0;
  end

  for (genvar g = 0; g < scv_pkg::DIV_CELLS; g++) begin : g_div
    scv_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .i_valid (dv_v[g]),
      .i_side  (dv_side[g]),
      .i_dv    (dv_st[g]),
      .o_valid (dv_v[g+1]),
      .o_side  (dv_side[g+1]),
      .o_dv    (dv_st[g+1])
    );
  end

  always_comb begin
    if (dv_st[scv_pkg::DIV_CELLS].q > scv_pkg::T_ONE) begin
      t_nxt = scv_pkg::T_ONE;
    end else begin
      t_nxt = dv_st[scv_pkg::DIV_CELLS].q;
    end
    for (int i = 0; i < 3; i++) begin
      contact[i] = p_st_r[i] + p_prod_r[i][scv_pkg::TFB +: scv_pkg::COORD_W];
    end
    if (p_ok_r) begin
      out_nxt = scv_pkg::OUT_TDATA_W'({contact[2], contact[1], contact[0], p_t_r, 1'b1});
    end else begin
      out_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r       <= 1'b0;
      p_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        e_v_r <= sq_v[scv_pkg::SQRT_CELLS];
        p_v_r <= dv_v[scv_pkg::DIV_CELLS];
      end
      if (out_tready || !out_valid_r) begin
        out_valid_r <= p_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_side_r <= sq_side[scv_pkg::SQRT_CELLS];
      e_num_r  <= e_num_nxt;
      p_ok_r   <= dv_side[scv_pkg::DIV_CELLS].ok;
      p_t_r    <= t_nxt;
      p_st_r   <= dv_side[scv_pkg::DIV_CELLS].st;
      for (int i = 0; i < 3; i++) begin
        p_prod_r[i] <= scv_pkg::mul_t(dv_side[scv_pkg::DIV_CELLS].mv[i], t_nxt);
      end
    end
    if (out_tready || !out_valid_r) begin
      out_data_r <= out_nxt;
    end
  end

  `SCV_ASSERT(a_time_max, out_tvalid && out_tdata[0] |-> out_tdata[scv_pkg::T_W:1] <= scv_pkg::T_ONE, "impact time above one")
  `SCV_ASSERT(a_miss_zero, out_tvalid && !out_tdata[0] |-> out_tdata == '0, "miss word not cleared")
  `SCV_ASSERT_NEXT(a_no_drop, p_v_r && out_tvalid && !out_tready, p_v_r && out_tvalid, "last stage lost during stall")

endmodule

### rtl/scv_front.sv
// Front pipeline: motion and offset vectors, the quadratic terms and the
// discriminant with its early miss tests. Depends on scv_pkg.
module scv_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             i_valid,
  input  logic [scv_pkg::IN_TDATA_W-1:0]   i_data,
  output logic                             o_valid,
  output scv_pkg::side_t                   o_side,
  output logic [scv_pkg::DISC_W-1:0]       o_disc
);

  logic                                v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  scv_pkg::diff_t [2:0]                m1_r, w1_r, m2_r, m3_r;
  scv_pkg::coord_t [2:0]               st1_r, st2_r, st3_r;
  logic [scv_pkg::RAD_W-1:0]           rad1_r;
  logic [2:0][scv_pkg::SQ_W-1:0]       mm2_r, ww2_r, wm2_r;
  logic [2*scv_pkg::RAD_W-1:0]         rr2_r, rr3_r;
  logic [scv_pkg::SUM_W-1:0]           a3_r, cw3_r, b3_r;
  scv_pkg::side_t                      s4_r, s4_nxt, s5_r, s6_r, s7_r, s7_nxt, o_nxt;
  logic [scv_pkg::SQ_W-1:0]            c4_r, dba4_r, dba4_nxt;
  logic [scv_pkg::SUM_W:0]             c_full;
  logic [2:0][2*scv_pkg::HALF_W-1:0]   bbp_r, ddp_r;
  logic [3:0][2*scv_pkg::HALF_W-1:0]   acp_r;
  logic [scv_pkg::DISC_W-1:0]          bb6_r, ac6_r, dd6_r, disc7_r, dd7_r;
  logic [scv_pkg::DISC_W:0]            d_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      v6_r    <= 1'b0;
      v7_r    <= 1'b0;
      o_valid <= 1'b0;
    end else if (en) begin
      v1_r    <= i_valid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      v5_r    <= v4_r;
      v6_r    <= v5_r;
      v7_r    <= v6_r;
      o_valid <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        st1_r[i] <= i_data[i*scv_pkg::COORD_W +: scv_pkg::COORD_W];
        m1_r[i]  <= scv_pkg::sub_ext(i_data[(3+i)*scv_pkg::COORD_W +: scv_pkg::COORD_W],
                                     i_data[i*scv_pkg::COORD_W +: scv_pkg::COORD_W]);
        w1_r[i]  <= scv_pkg::sub_ext(i_data[(6+i)*scv_pkg::COORD_W +: scv_pkg::COORD_W],
                                     i_data[i*scv_pkg::COORD_W +: scv_pkg::COORD_W]);
        mm2_r[i] <= scv_pkg::mul_s(m1_r[i], m1_r[i]);
        ww2_r[i] <= scv_pkg::mul_s(w1_r[i], w1_r[i]);
        wm2_r[i] <= scv_pkg::mul_s(w1_r[i], m1_r[i]);
      end
      rad1_r <= i_data[9*scv_pkg::COORD_W +: scv_pkg::RAD_W];
      rr2_r  <= rad1_r * rad1_r;
      m2_r   <= m1_r;
      st2_r  <= st1_r;
      a3_r   <= scv_pkg::SUM_W'(mm2_r[0]) + scv_pkg::SUM_W'(mm2_r[1])
              + scv_pkg::SUM_W'(mm2_r[2]);
      cw3_r  <= scv_pkg::SUM_W'(ww2_r[0]) + scv_pkg::SUM_W'(ww2_r[1])
              + scv_pkg::SUM_W'(ww2_r[2]);
      b3_r   <= {{2{wm2_r[0][scv_pkg::SQ_W-1]}}, wm2_r[0]}
              + {{2{wm2_r[1][scv_pkg::SQ_W-1]}}, wm2_r[1]}
              + {{2{wm2_r[2][scv_pkg::SQ_W-1]}}, wm2_r[2]};
      rr3_r  <= rr2_r;
      m3_r   <= m2_r;
      st3_r  <= st2_r;
      s4_r   <= s4_nxt;
      c4_r   <= c_full[scv_pkg::SQ_W-1:0];
      dba4_r <= dba4_nxt;
    end
  end

  always_comb begin
    c_full    = {1'b0, cw3_r} - (scv_pkg::SUM_W + 1)'(rr3_r);
    s4_nxt.ok = (a3_r != '0) && !b3_r[scv_pkg::SUM_W-1] && !c_full[scv_pkg::SUM_W];
    s4_nxt.a  = a3_r[scv_pkg::SQ_W-1:0];
    s4_nxt.b  = b3_r[scv_pkg::SQ_W-1:0];
    s4_nxt.mv = m3_r;
    s4_nxt.st = st3_r;
    if (!b3_r[scv_pkg::SUM_W-1] && (b3_r[scv_pkg::SQ_W-1:0] > a3_r[scv_pkg::SQ_W-1:0])) begin
      dba4_nxt = b3_r[scv_pkg::SQ_W-1:0] - a3_r[scv_pkg::SQ_W-1:0];
    end else begin
      dba4_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bbp_r[0] <= scv_pkg::umul_h(s4_r.b[scv_pkg::HALF_W-1:0], s4_r.b[scv_pkg::HALF_W-1:0]);
      bbp_r[1] <= scv_pkg::umul_h(s4_r.b[scv_pkg::HALF_W-1:0],
                                  s4_r.b[scv_pkg::SQ_W-1:scv_pkg::HALF_W]);
      bbp_r[2] <= scv_pkg::umul_h(s4_r.b[scv_pkg::SQ_W-1:scv_pkg::HALF_W],
                                  s4_r.b[scv_pkg::SQ_W-1:scv_pkg::HALF_W]);
      acp_r[0] <= scv_pkg::umul_h(s4_r.a[scv_pkg::HALF_W-1:0], c4_r[scv_pkg::HALF_W-1:0]);
      acp_r[1] <= scv_pkg::umul_h(s4_r.a[scv_pkg::HALF_W-1:0],
                                  c4_r[scv_pkg::SQ_W-1:scv_pkg::HALF_W]);
      acp_r[2] <= scv_pkg::umul_h(s4_r.a[scv_pkg::SQ_W-1:scv_pkg::HALF_W],
                                  c4_r[scv_pkg::HALF_W-1:0]);
      acp_r[3] <= scv_pkg::umul_h(s4_r.a[scv_pkg::SQ_W-1:scv_pkg::HALF_W],
                                  c4_r[scv_pkg::SQ_W-1:scv_pkg::HALF_W]);
      ddp_r[0] <= scv_pkg::umul_h(dba4_r[scv_pkg::HALF_W-1:0], dba4_r[scv_pkg::HALF_W-1:0]);
      ddp_r[1] <= scv_pkg::umul_h(dba4_r[scv_pkg::HALF_W-1:0],
                                  dba4_r[scv_pkg::SQ_W-1:scv_pkg::HALF_W]);
      ddp_r[2] <= scv_pkg::umul_h(dba4_r[scv_pkg::SQ_W-1:scv_pkg::HALF_W],
                                  dba4_r[scv_pkg::SQ_W-1:scv_pkg::HALF_W]);
      s5_r     <= s4_r;
      bb6_r    <= {bbp_r[2], bbp_r[0]}
                + (scv_pkg::DISC_W'(bbp_r[1]) << (scv_pkg::HALF_W + 1));
      ac6_r    <= {acp_r[3], acp_r[0]}
                + (scv_pkg::DISC_W'(acp_r[1]) << scv_pkg::HALF_W)
                + (scv_pkg::DISC_W'(acp_r[2]) << scv_pkg::HALF_W);
      dd6_r    <= {ddp_r[2], ddp_r[0]}
                + (scv_pkg::DISC_W'(ddp_r[1]) << (scv_pkg::HALF_W + 1));
      s6_r     <= s5_r;
      disc7_r  <= d_full[scv_pkg::DISC_W-1:0];
      dd7_r    <= dd6_r;
      s7_r     <= s7_nxt;
      o_disc   <= disc7_r;
      o_side   <= o_nxt;
    end
  end

  // The squared excess of B over A is zero unless B > A, so the compare
  // below only rejects entries that lie beyond the end of the path.
  always_comb begin
    d_full    = {1'b0, bb6_r} - {1'b0, ac6_r};
    s7_nxt    = s6_r;
    s7_nxt.ok = s6_r.ok && !d_full[scv_pkg::DISC_W];
    o_nxt     = s7_r;
    o_nxt.ok  = s7_r.ok && !(dd7_r > disc7_r);
  end

endmodule

### rtl/scv_sqrt_cell.sv
// One digit of the square root chain: two radicand bits in, one root bit out.
// Depends on scv_pkg.
module scv_sqrt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            i_valid,
  input  scv_pkg::side_t  i_side,
  input  scv_pkg::sqrt_t  i_sq,
  output logic            o_valid,
  output scv_pkg::side_t  o_side,
  output scv_pkg::sqrt_t  o_sq
);

  logic [scv_pkg::REM_W+1:0] cur, trial, diff;
  logic                      ge;
  scv_pkg::sqrt_t            sq_nxt;

  always_comb begin
    cur         = {i_sq.rem, i_sq.rad[scv_pkg::DISC_W-1 -: 2]};
    trial       = {1'b0, i_sq.root, 2'b01};
    diff        = cur - trial;
    ge          = cur >= trial;
    sq_nxt.rad  = {i_sq.rad[scv_pkg::DISC_W-3:0], 2'b00};
    sq_nxt.rem  = ge ? diff[scv_pkg::REM_W-1:0] : cur[scv_pkg::REM_W-1:0];
    sq_nxt.root = {i_sq.root[scv_pkg::ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_side <= i_side;
      o_sq   <= sq_nxt;
    end
  end

endmodule

### rtl/scv_div_cell.sv
// One quotient bit of the entry time division by the squared path length.
// Depends on scv_pkg.
module scv_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            i_valid,
  input  scv_pkg::side_t  i_side,
  input  scv_pkg::div_t   i_dv,
  output logic            o_valid,
  output scv_pkg::side_t  o_side,
  output scv_pkg::div_t   o_dv
);

  logic [scv_pkg::DIV_W-1:0] den, diff, sel;
  logic                      ge;
  scv_pkg::div_t             dv_nxt;

  always_comb begin
    den      = {1'b0, i_side.a};
    diff     = i_dv.r - den;
    ge       = i_dv.r >= den;
    sel      = ge ? diff : i_dv.r;
    dv_nxt.r = {sel[scv_pkg::DIV_W-2:0], 1'b0};
    dv_nxt.q = {i_dv.q[scv_pkg::T_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_side <= i_side;
      o_dv   <= dv_nxt;
    end
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for swept_circle_static_circle: swept point against fixed sphere.
// Predicts entry time and contact point with wide exact integers; depends on scv_pkg.
module tb_top;

  localparam int WB = 200;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int ONE = 1 << scv_pkg::TFB;

  typedef logic signed [WB-1:0] wide_t;

  typedef struct packed {
    logic                      hit;
    logic [scv_pkg::T_W-1:0]   t;
    scv_pkg::coord_t           cx;
    scv_pkg::coord_t           cy;
    scv_pkg::coord_t           cz;
  } impact_t;

  typedef struct {
    scv_pkg::coord_t           p [9];
    logic [scv_pkg::RAD_W-1:0] r;
    logic                      typed;
    impact_t                   res;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [scv_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [scv_pkg::OUT_TDATA_W-1:0] out_tdata;

  impact_t impact_q [$];
  int tx_idle = 0, rx_idle = 0, hold_cycles = 0;
  int fails = 0, cycles = 0;
  row_t rows [$];

  swept_circle_static_circle dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #10 clk = ~clk;

  function automatic wide_t ceil_root(input wide_t v);
    logic [WB-1:0] res, cand, uv;
    uv = v;
    res = '0;
    for (int i = WB / 2 - 1; i >= 0; i--) begin
      cand = res | (WB'(1) << i);
      if (cand * cand <= uv) res = cand;
    end
    if (res * res != uv) res = res + 1;
    return wide_t'(res);
  endfunction

  function automatic impact_t predict_impact(input logic [scv_pkg::IN_TDATA_W-1:0] d);
    wide_t a, b, c, disc, q, num, rr, tw, mvw [3], stw [3], pos;
    scv_pkg::diff_t mv, rel;
    scv_pkg::coord_t st;
    impact_t o;
    a = 0; b = 0; c = 0;
    for (int i = 0; i < 3; i++) begin
      st = d[i*scv_pkg::COORD_W +: scv_pkg::COORD_W];
      mv = scv_pkg::sub_ext(scv_pkg::coord_t'(d[(3+i)*scv_pkg::COORD_W +: scv_pkg::COORD_W]),
                            st);
      rel = scv_pkg::sub_ext(scv_pkg::coord_t'(d[(6+i)*scv_pkg::COORD_W +: scv_pkg::COORD_W]),
                             st);
      mvw[i] = mv;
      stw[i] = st;
      a = a + wide_t'(mv) * wide_t'(mv);
      b = b + wide_t'(rel) * wide_t'(mv);
      c = c + wide_t'(rel) * wide_t'(rel);
    end
    rr = wide_t'({1'b0, d[9*scv_pkg::COORD_W +: scv_pkg::RAD_W]});
    c = c - rr * rr;
    o = '0;
    if (a == 0 || b < 0 || c < 0) return o;
    disc = b * b - a * c;
    if (disc < 0) return o;
    if (b > a && (b - a) * (b - a) > disc) return o;
    q = ceil_root(disc);
    num = (q > b) ? wide_t'(0) : b - q;
    tw = (num * ONE) / a;
    if (tw > ONE) tw = ONE;
    o.hit = 1'b1;
    o.t = tw[scv_pkg::T_W-1:0];
    pos = stw[0] + ((mvw[0] * tw) >>> scv_pkg::TFB); o.cx = pos[scv_pkg::COORD_W-1:0];
    pos = stw[1] + ((mvw[1] * tw) >>> scv_pkg::TFB); o.cy = pos[scv_pkg::COORD_W-1:0];
    pos = stw[2] + ((mvw[2] * tw) >>> scv_pkg::TFB); o.cz = pos[scv_pkg::COORD_W-1:0];
    return o;
  endfunction

  function automatic logic [scv_pkg::IN_TDATA_W-1:0] pack_query(
      input scv_pkg::coord_t p [9], input logic [scv_pkg::RAD_W-1:0] r);
    logic [scv_pkg::IN_TDATA_W-1:0] d;
    d = '0;
    for (int i = 0; i < 9; i++) d[i*scv_pkg::COORD_W +: scv_pkg::COORD_W] = p[i];
    d[9*scv_pkg::COORD_W +: scv_pkg::RAD_W] = r;
    return d;
  endfunction

  task automatic add_row(input int sx, sy, sz, ex, ey, ez, cx, cy, cz, input int r,
                         input logic typed, input impact_t res);
    row_t w;
    w.p = '{sx, sy, sz, ex, ey, ez, cx, cy, cz};
    w.r = scv_pkg::RAD_W'(r);
    w.typed = typed;
    w.res = res;
    rows.push_back(w);
  endtask

  task automatic send_query(input logic [scv_pkg::IN_TDATA_W-1:0] d, input logic typed,
                            input impact_t res);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    impact_q.push_back(typed ? res : predict_impact(d));
  endtask

  task automatic send_random(input int n);
    scv_pkg::coord_t p [9];
    logic [scv_pkg::RAD_W-1:0] r;
    int sh, k;
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(3) == 0) begin
        foreach (p[i]) p[i] = $urandom;
        r = scv_pkg::RAD_W'($urandom);
      end else begin
        sh = $urandom_range(8, 20);
        for (int i = 0; i < 3; i++) begin
          p[i] = $signed($urandom) >>> 8;
          p[3+i] = p[i] + ($signed($urandom) >>> sh);
          k = $urandom_range(0, 6);
          p[6+i] = p[i] + (((p[3+i] - p[i]) >>> 2) * k) + ($signed($urandom) >>> (sh + 2));
        end
        r = scv_pkg::RAD_W'($urandom >> ($urandom_range(1, 24) + (sh > 14 ? 8 : 0)));
        if ($urandom_range(15) == 0) for (int i = 0; i < 3; i++) p[3+i] = p[i];
      end
      send_query(pack_query(p, r), 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    impact_t got, want;
    cycles <= cycles + 1;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.hit = out_tdata[0];
      got.t   = out_tdata[scv_pkg::T_W:1];
      got.cx  = out_tdata[scv_pkg::T_W+1 +: scv_pkg::COORD_W];
      got.cy  = out_tdata[scv_pkg::T_W+1+scv_pkg::COORD_W +: scv_pkg::COORD_W];
      got.cz  = out_tdata[scv_pkg::T_W+1+2*scv_pkg::COORD_W +: scv_pkg::COORD_W];
      if (impact_q.size() == 0) begin
        fails <= fails + 1;
        if (fails < 10) $display("Unexpected word: %h", got);
      end else begin
        want = impact_q.pop_front();
        if (got.hit !== want.hit || got.t !== want.t || got.cx !== want.cx ||
            got.cy !== want.cy || got.cz !== want.cz) begin
          fails <= fails + 1;
          if (fails < 10)
            $display("Mismatch: expected hit=%0d t=%0d c=(%h,%h,%h) got hit=%0d t=%0d c=(%h,%h,%h)",
                     want.hit, want.t, want.cx, want.cy, want.cz,
                     got.hit, got.t, got.cx, got.cy, got.cz);
        end
      end
    end
  end

  initial begin
    int u, waited;
    u = 1 << 16;
    // Zero-length path, centre behind, start inside, start on the surface.
    add_row(u, u, u, u, u, u, 3*u, u, u, u, 1, '0);
    add_row(0, 0, 0, 4*u, 0, 0, -2*u, 0, 0, u, 1, '0);
    add_row(0, 0, 0, 4*u, 0, 0, u/2, 0, 0, u, 1, '0);
    add_row(0, 0, 0, 4*u, 0, 0, u, 0, 0, u, 1, '{1'b1, 17'd0, 0, 0, 0});
    // Plain entry, tangent touch, graze past the end, entry exactly at the end, entry along z, clear miss.
    add_row(0, 0, 0, 4*u, 0, 0, 2*u, 0, 0, u, 1, '{1'b1, 17'd16384, u, 0, 0});
    add_row(0, 0, 0, 4*u, 0, 0, 2*u, u, 0, u, 1, '{1'b1, 17'd32768, 2*u, 0, 0});
    add_row(0, 0, 0, 4*u, 0, 0, 6*u, 0, 0, u, 1, '0);
    add_row(0, 0, 0, 4*u, 0, 0, 5*u, 0, 0, u, 1, '{1'b1, 17'd65536, 4*u, 0, 0});
    add_row(0, 0, 0, 0, 0, -4*u, 0, 0, -2*u, u, 1, '{1'b1, 17'd16384, 0, 0, -u});
    add_row(0, 0, 0, 4*u, 0, 0, 2*u, 2*u, 0, u, 1, '0);
    // Extremes of every field and tiny coordinates.
    add_row(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
            32'h7fffffff, 0, 0, 0, 32'h7fffffff, 0, '0);
    add_row(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
            32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, '0);
    add_row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
            32'h80000000, 0, 0, 0, 32'h7fffffff, 0, '0);
    add_row(32'h7fffffff, 0, 32'h80000000, 32'h80000000, 0, 32'h7fffffff,
            32'h80000000, 32'h7fffffff, 0, 32'h40000000, 0, '0);
    add_row(-1, -1, -1, 1, 1, 1, 0, 0, 0, 1, 0, '0);
    add_row(0, 0, 0, 3, 0, 0, 1, 1, 0, 1, 0, '0);
    add_row(32'h80000000, 0, 0, 32'h80000000, 0, 0, 0, 0, 0, 32'h7fffffff, 0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle = 21; rx_idle = 82;
    foreach (rows[i]) send_query(pack_query(rows[i].p, rows[i].r), rows[i].typed, rows[i].res);
    send_random(510);
    tx_idle = 82; rx_idle = 21;
    send_random(510);
    tx_idle = 0; rx_idle = 0;
    hold_cycles = 400;
    send_random(510);
    @(negedge clk);
    in_tvalid <= 1'b0;

    waited = 0;
    while (impact_q.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (fails == 0 && impact_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
